[rtl/spc_pkg.sv]
// shared types, codes and constants of the slip packet codec
package spc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned LEN_W  = 5;

  localparam int unsigned PACKET_DEPTH_DEF = 16;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // slip special bytes
  localparam logic [BYTE_W-1:0] SLIP_END     = 8'o300;
  localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'o333;
  localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'o334;
  localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'o335;

  // request codes on the input channel
  localparam logic [1:0] REQ_RX   = 2'd0;
  localparam logic [1:0] REQ_WR   = 2'd1;
  localparam logic [1:0] REQ_SEND = 2'd2;

  // result kinds
  localparam logic KIND_RX_STATUS = 1'b0;
  localparam logic KIND_TX_BYTE   = 1'b1;

  typedef enum logic [1:0] {
    CMD_RX,
    CMD_WR,
    CMD_SEND
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [BYTE_W-1:0]  data;
    logic [IDX_W-1:0]   idx;
    logic [LEN_W-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [LEN_W-1:0]   plen;
    logic               sv;
    logic [IDX_W-1:0]   sidx;
    logic [BYTE_W-1:0]  sbyte;
    logic [BYTE_W-1:0]  txb;
    logic               txl;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_EMIT2,
    ST_TAIL
  } back_state_e;

endpackage

[rtl/spc_front.sv]
// front end: takes input words, classifies them and pushes commands
module spc_front #(
  parameter int unsigned PACKET_DEPTH = spc_pkg::PACKET_DEPTH_DEF
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [spc_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic [spc_pkg::IDX_W-1:0]     buffer_index_i,
  input  logic [spc_pkg::LEN_W-1:0]     send_length_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output spc_pkg::cmd_t                 q_cmd_o
);

  localparam logic [spc_pkg::LEN_W-1:0] DepthC = spc_pkg::LEN_W'(PACKET_DEPTH);

  logic keep;
  logic idx_ok;

  assign idx_ok = {1'b0, buffer_index_i} < DepthC;
  assign in_ready_o = !q_full_i;

  always_comb begin
    keep         = 1'b0;
    q_cmd_o.kind = spc_pkg::CMD_RX;
    q_cmd_o.data = data_byte_i;
    q_cmd_o.idx  = buffer_index_i;
    q_cmd_o.len  = (send_length_i > DepthC) ? DepthC : send_length_i;
    unique case (req_type_i)
      spc_pkg::REQ_RX: begin
        keep         = 1'b1;
        q_cmd_o.kind = spc_pkg::CMD_RX;
      end
      spc_pkg::REQ_WR: begin
        // writes past the store are dropped here
        keep         = idx_ok;
        q_cmd_o.kind = spc_pkg::CMD_WR;
      end
      spc_pkg::REQ_SEND: begin
        keep         = 1'b1;
        q_cmd_o.kind = spc_pkg::CMD_SEND;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push_o = in_valid_i && in_ready_o && keep;

endmodule

[rtl/spc_cmd_fifo.sv]
// small command queue between front and back
module spc_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spc_pkg::cmd_t  cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output spc_pkg::cmd_t  cmd_o
);

  spc_pkg::cmd_t                 mem_q [spc_pkg::CMDQ_DEPTH];
  logic [spc_pkg::CMDQ_AW-1:0]   wr_q, wr_d;
  logic [spc_pkg::CMDQ_AW-1:0]   rd_q, rd_d;
  logic [spc_pkg::CMDQ_AW:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  localparam logic [spc_pkg::CMDQ_AW:0] DepthC = (spc_pkg::CMDQ_AW + 1)'(spc_pkg::CMDQ_DEPTH);

  assign full_o  = (cnt_q == DepthC);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

[rtl/spc_back.sv]
// back end: receive decoder, packet store, send sequencer and output register
module spc_back #(
  parameter int unsigned PACKET_DEPTH = spc_pkg::PACKET_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  spc_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spc_pkg::res_t  out_res_o
);

  localparam int unsigned AW = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1;
  localparam logic [spc_pkg::LEN_W-1:0] DepthC = spc_pkg::LEN_W'(PACKET_DEPTH);

  logic [spc_pkg::BYTE_W-1:0] store_q [PACKET_DEPTH];
  logic [spc_pkg::BYTE_W-1:0] rd_q;

  spc_pkg::back_state_e       state_q, state_d;
  logic [spc_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic                       esc_q, esc_d;
  logic [spc_pkg::LEN_W-1:0]  ptr_q, ptr_d;
  logic [spc_pkg::LEN_W-1:0]  len_q, len_d;

  logic                       ov_q;
  spc_pkg::res_t              res_q;

  logic                       load_ok;
  logic                       emit;
  spc_pkg::res_t              res_d;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [spc_pkg::BYTE_W-1:0] wd;
  logic                       re;
  logic [spc_pkg::BYTE_W-1:0] dec;
  logic                       rd_special;

  assign load_ok    = !ov_q || out_ready_i;
  assign rd_special = (rd_q == spc_pkg::SLIP_END) || (rd_q == spc_pkg::SLIP_ESC);

  // de-stuffed value of a received byte
  always_comb begin
    dec = cmd_i.data;
    if (esc_q && cmd_i.data == spc_pkg::SLIP_ESC_ESC) begin
      dec = spc_pkg::SLIP_ESC;
    end else if (esc_q && cmd_i.data == spc_pkg::SLIP_ESC_END) begin
      dec = spc_pkg::SLIP_END;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spc_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == spc_pkg::CMD_SEND) begin
          state_d = spc_pkg::ST_FETCH;
        end
      end
      spc_pkg::ST_FETCH: begin
        state_d = (ptr_q != len_q) ? spc_pkg::ST_EMIT : spc_pkg::ST_TAIL;
      end
      spc_pkg::ST_EMIT: begin
        if (load_ok) begin
          state_d = rd_special ? spc_pkg::ST_EMIT2 : spc_pkg::ST_FETCH;
        end
      end
      spc_pkg::ST_EMIT2: begin
        if (load_ok) begin
          state_d = spc_pkg::ST_FETCH;
        end
      end
      spc_pkg::ST_TAIL: begin
        if (load_ok) begin
          state_d = spc_pkg::ST_IDLE;
        end
      end
      default: state_d = spc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    res_d     = '0;
    we        = 1'b0;
    wa        = cnt_q[AW-1:0];
    wd        = dec;
    re        = 1'b0;
    cnt_d     = cnt_q;
    esc_d     = esc_q;
    ptr_d     = ptr_q;
    len_d     = len_q;
    unique case (state_q)
      spc_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            spc_pkg::CMD_RX: begin
              if (load_ok) begin
                cmd_pop_o  = 1'b1;
                emit       = 1'b1;
                res_d.kind = spc_pkg::KIND_RX_STATUS;
                if (cmd_i.data == spc_pkg::SLIP_END) begin
                  res_d.plen = cnt_q;
                  cnt_d      = '0;
                end else if (cmd_i.data == spc_pkg::SLIP_ESC) begin
                  esc_d = 1'b1;
                end else begin
                  esc_d = 1'b0;
                  if (cnt_q < DepthC) begin
                    we          = 1'b1;
                    cnt_d       = cnt_q + 1'b1;
                    res_d.sv    = 1'b1;
                    res_d.sidx  = cnt_q[spc_pkg::IDX_W-1:0];
                    res_d.sbyte = dec;
                  end else begin
                    // store full: drop the byte, report the depth
                    cnt_d      = '0;
                    res_d.plen = DepthC;
                  end
                end
              end
            end
            spc_pkg::CMD_WR: begin
              cmd_pop_o = 1'b1;
              we        = 1'b1;
              wa        = AW'({1'b0, cmd_i.idx});
              wd        = cmd_i.data;
            end
            spc_pkg::CMD_SEND: begin
              cmd_pop_o = 1'b1;
              len_d     = cmd_i.len;
              ptr_d     = '0;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      spc_pkg::ST_FETCH: begin
        re = (ptr_q != len_q);
      end
      spc_pkg::ST_EMIT: begin
        if (load_ok) begin
          emit       = 1'b1;
          res_d.kind = spc_pkg::KIND_TX_BYTE;
          if (rd_special) begin
            res_d.txb = spc_pkg::SLIP_ESC;
          end else begin
            res_d.txb = rd_q;
            ptr_d     = ptr_q + 1'b1;
          end
        end
      end
      spc_pkg::ST_EMIT2: begin
        if (load_ok) begin
          emit       = 1'b1;
          res_d.kind = spc_pkg::KIND_TX_BYTE;
          res_d.txb  = (rd_q == spc_pkg::SLIP_END) ? spc_pkg::SLIP_ESC_END
                                                   : spc_pkg::SLIP_ESC_ESC;
          ptr_d      = ptr_q + 1'b1;
        end
      end
      spc_pkg::ST_TAIL: begin
        if (load_ok) begin
          emit       = 1'b1;
          res_d.kind = spc_pkg::KIND_TX_BYTE;
          res_d.txb  = spc_pkg::SLIP_END;
          res_d.txl  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spc_pkg::ST_IDLE;
      cnt_q   <= '0;
      esc_q   <= 1'b0;
      ptr_q   <= '0;
      len_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      esc_q   <= esc_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  // packet store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= store_q[ptr_q[AW-1:0]];
    end
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

endmodule

[rtl/slip_packet_codec.sv]
// top level of the slip packet codec
//
// input stream (s_axis): one word per request. tuser carries the request
// type: received line byte, store write, or send packet. tdata carries the
// byte, the store index and the send length.
// output stream (m_axis): tuser = 0 for a receive status word, 1 for a
// transmitted line byte; tlast marks the closing END of a sent packet.
// a received byte gives one status word, a store write gives none, a send
// gives one word per stuffed line byte plus the closing END.
// a received byte's status passes through the command queue and the output
// register. throughput for received bytes and writes is one word per cycle
// while no send runs and the output is not stalled, set by the back end
// handling one command per cycle. a send pops its command, then reads and
// emits each store byte, an escaped one as two words, then checks the
// length again and emits END. the front end keeps accepting into a 4-entry
// command queue while the back end works, and stalls only when it is full.
// reset clears the receive count, the escape flag, the queue and the
// output valid flag; the packet store is not cleared and must be written
// before it is sent.
// when the receiver stalls, the output word holds and no new word is emitted.
module slip_packet_codec #(
  parameter int unsigned PACKET_DEPTH = spc_pkg::PACKET_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [11:8] buffer_index, [16:12] send_length, rest zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] packet_length, [5] stored_valid, [9:6] stored_index,
  // [17:10] stored_byte, [25:18] tx_byte, rest zero
  output logic [31:0] m_axis_tdata,
  // [0] out_kind
  output logic        m_axis_tuser,
  // tx_last
  output logic        m_axis_tlast
);

  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_valid;
  logic          cmd_pop;
  spc_pkg::cmd_t cmd_in;
  spc_pkg::cmd_t cmd_out;
  spc_pkg::res_t res;

  // classify requests, cap send length, drop bad writes and unknown codes
  spc_front #(
    .PACKET_DEPTH (PACKET_DEPTH)
  ) u_front (
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .buffer_index_i (s_axis_tdata[11:8]),
    .send_length_i  (s_axis_tdata[16:12]),
    .q_full_i       (cmd_full),
    .q_push_o       (cmd_push),
    .q_cmd_o        (cmd_in)
  );

  // decouples the front from the back end
  spc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out)
  );

  // receive decode, store and send sequencing
  spc_back #(
    .PACKET_DEPTH (PACKET_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {6'd0, res.txb, res.sbyte, res.sidx, res.sv, res.plen};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.txl;

  // the front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && cmd_full))
    else $error("command pushed into full queue");

  // end of packet only on transmitted bytes, and always as END
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser == spc_pkg::KIND_TX_BYTE && res.txb == spc_pkg::SLIP_END))
    else $error("tlast on a word that is not a closing END");

  // a status word never carries transmit fields
  a_rx_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == spc_pkg::KIND_RX_STATUS) |->
      (res.txb == '0 && !res.txl))
    else $error("transmit fields set in a receive status word");

  // a transmitted byte never carries receive fields
  a_tx_no_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == spc_pkg::KIND_TX_BYTE) |->
      (res.plen == '0 && !res.sv && res.sidx == '0 && res.sbyte == '0))
    else $error("receive fields set in a transmitted byte");

endmodule
